// ===== hdl/safq_pkg.sv =====
`default_nettype none

package safq_pkg;

  // Slot numbers are 8 bits wide, so the pool never exceeds 256 slots.
  localparam int SlotW       = 8;
  localparam int MaxDepth    = 256;
  localparam int CfgW        = 9;
  localparam int SlotsDefault = 256;
  localparam logic [CfgW-1:0] PoolSizeReset = 9'd256;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } safq_func_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_NEVER     = 2'd2,
    STATUS_ALREADY   = 2'd3
  } safq_status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } safq_state_e;

  typedef struct packed {
    safq_func_e             func;
    logic [SlotW-1:0]       slot_number;
  } safq_req_t;

  typedef struct packed {
    logic                   ok;
    logic [SlotW-1:0]       granted_slot;
    safq_status_e           status;
  } safq_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/safq_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module safq_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/slot_allocator_free_queue.sv =====
`default_nettype none

// Slot allocator with a FIFO free queue.
// Request channel (in_valid_i/in_ready_o/in_req_i): func selects allocate or
// free; slot_number names the slot to free and is ignored on allocate.
// Response channel (out_valid_o/out_ready_i/out_rsp_o): exactly one response
// per request, in request order: ok, granted_slot and a status code.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes pool_size; the
// port is always ready. Write it only while no request is in flight.
// Timing: a request accepted in the idle state is resolved in the lookup
// state, which registers its response once the output register is free. A
// new request is not taken until the last one has left the lookup state:
// the free queue and the freed-mark bitmap live in RAMs with registered
// reads, and a request reads at acceptance and writes back in lookup.
// Reset: pool_size returns to 256, counters and queue pointers clear, and a
// clearing pass sweeps the freed-mark RAM one entry per cycle, with in_ready_o
// held low; config writes still land.
// Stall: a response waiting in the output register does not block the next
// acceptance; a finished lookup holds until the output register drains.
module slot_allocator_free_queue #(
  parameter int SLOTS = safq_pkg::SlotsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire safq_pkg::safq_req_t           in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output safq_pkg::safq_rsp_t                out_rsp_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [safq_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int SlotW = safq_pkg::SlotW;
  localparam int CfgW  = safq_pkg::CfgW;
  // Slots above 255 cannot be named, so storage stops at 256 entries.
  localparam int Depth = (SLOTS < safq_pkg::MaxDepth) ? SLOTS : safq_pkg::MaxDepth;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  safq_pkg::safq_state_e state_q, state_d;

  logic [CfgW-1:0]  pool_size_q;
  logic [CntW-1:0]  bump_q, bump_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  logic [IdxW-1:0]  clr_q;
  safq_pkg::safq_req_t req_q;
  safq_pkg::safq_rsp_t rsp_q, rsp_d;
  logic             out_valid_q;

  logic             accept;
  logic             finish;
  logic             clearing;
  logic [CntW-1:0]  limit;
  logic             bump_avail;
  logic             slot_never;

  logic [SlotW-1:0] q_rdata;
  logic             q_we;
  logic [0:0]       mark_rdata;
  logic             mark_we;
  logic [IdxW-1:0]  mark_waddr;
  logic [0:0]       mark_wdata;
  logic             lk_mark_we;
  logic [IdxW-1:0]  lk_mark_waddr;
  logic             lk_mark_set;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      safq_pkg::ST_CLEAR: begin
        if (clr_q == LastIdx) begin
          state_d = safq_pkg::ST_IDLE;
        end
      end
      safq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = safq_pkg::ST_LOOKUP;
        end
      end
      safq_pkg::ST_LOOKUP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = safq_pkg::ST_IDLE;
        end
      end
      default: state_d = safq_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------
  // State outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    clearing   = 1'b0;
    finish     = 1'b0;
    case (state_q)
      safq_pkg::ST_CLEAR:  clearing   = 1'b1;
      safq_pkg::ST_IDLE:   in_ready_o = 1'b1;
      // Hold the lookup until the output register can take the response.
      safq_pkg::ST_LOOKUP: finish     = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Effective pool size: pool_size capped at the storage depth.
  assign limit      = (pool_size_q > 9'(Depth)) ? CntW'(Depth) : CntW'(pool_size_q);
  assign bump_avail = bump_q < limit;
  assign slot_never = {1'b0, req_q.slot_number} >= 9'(bump_q);

  // ---------------------------------------------------------------------
  // Request resolution: runs in the lookup cycle, when the RAM reads of
  // queue head and freed mark issued at acceptance are available.
  // ---------------------------------------------------------------------
  always_comb begin
    bump_d        = bump_q;
    count_d       = count_q;
    head_d        = head_q;
    tail_d        = tail_q;
    rsp_d         = rsp_q;
    q_we          = 1'b0;
    lk_mark_we    = 1'b0;
    lk_mark_waddr = req_q.slot_number[IdxW-1:0];
    lk_mark_set   = 1'b0;
    if (finish) begin
      rsp_d.ok           = 1'b0;
      rsp_d.granted_slot = '0;
      rsp_d.status       = safq_pkg::STATUS_DONE;
      case (req_q.func)
        safq_pkg::FUNC_ALLOC: begin
          if (count_q != '0) begin
            // Reuse the oldest freed slot and drop its mark.
            rsp_d.ok           = 1'b1;
            rsp_d.granted_slot = q_rdata;
            head_d             = (head_q == LastIdx) ? '0 : head_q + 1'b1;
            count_d            = count_q - 1'b1;
            lk_mark_we         = 1'b1;
            lk_mark_waddr      = q_rdata[IdxW-1:0];
          end else if (bump_avail) begin
            rsp_d.ok           = 1'b1;
            rsp_d.granted_slot = SlotW'(bump_q);
            bump_d             = bump_q + 1'b1;
          end else begin
            rsp_d.status = safq_pkg::STATUS_EXHAUSTED;
          end
        end
        safq_pkg::FUNC_FREE: begin
          if (slot_never) begin
            rsp_d.status = safq_pkg::STATUS_NEVER;
          end else if (mark_rdata[0]) begin
            rsp_d.status = safq_pkg::STATUS_ALREADY;
          end else begin
            // Queue the slot at the tail and set its mark.
            rsp_d.ok    = 1'b1;
            q_we        = 1'b1;
            tail_d      = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
            count_d     = count_q + 1'b1;
            lk_mark_we  = 1'b1;
            lk_mark_set = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Mark RAM write port: the clearing sweep owns it after reset.
  always_comb begin
    if (clearing) begin
      mark_we    = 1'b1;
      mark_waddr = clr_q;
      mark_wdata = 1'b0;
    end else begin
      mark_we    = lk_mark_we;
      mark_waddr = lk_mark_waddr;
      mark_wdata = lk_mark_set;
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= safq_pkg::ST_CLEAR;
      pool_size_q <= safq_pkg::PoolSizeReset;
      bump_q      <= '0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bump_q  <= bump_d;
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      if (cfg_valid_i) begin
        pool_size_q <= cfg_data_i;
      end
      if (clearing) begin
        clr_q <= clr_q + 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // ---------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------
  safq_ram #(
    .Width (SlotW),
    .Depth (Depth)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q),
    .wdata_i (req_q.slot_number),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  safq_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (accept),
    .raddr_i (in_req_i.slot_number[IdxW-1:0]),
    .rdata_o (mark_rdata)
  );

endmodule

`default_nettype wire
